>>> hw/rtl/fbe_pkg.sv
// Shared types and constants for the mono frame buffer engine.
package fbe_pkg;

	localparam int MAX_PITCH_BYTES_DEF = 32;
	localparam int MAX_ROWS_DEF        = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [8:0] WIDTH_RST  = 9'd128;
	localparam logic [6:0] HEIGHT_RST = 7'd64;
	localparam logic [5:0] PITCH_RST  = 6'd16;

	localparam logic [7:0] PIX_MSB   = 8'h80;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [5:0] PITCH_MIN = 6'h01;

	typedef enum logic [2:0] {
		ACT_SET  = 3'd0,
		ACT_GET  = 3'd1,
		ACT_WR8  = 3'd2,
		ACT_RD8  = 3'd3,
		ACT_FILL = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PITCH  = 2'd2,
		REG_BG     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

	// effective geometry, already saturated
	typedef struct packed {
		logic [8:0] width;
		logic [6:0] height;
		logic [5:0] pitch;
		logic       bg;
	} geom_t;

endpackage

>>> hw/rtl/mono_framebuffer_engine_top.sv
// Top level of the mono frame buffer engine: registers, sequencer and frame store.
// Accept to done: set/get pixel walk one byte, write/read eight two, fill every stored byte
//   covered (bytes per row times rows), unknown action or empty fill no byte; ST_READ reads and
//   ST_WRITE modifies each byte. A new request transfers in the cycle the last result is out.
// The receiver cannot stall: done is high for exactly one cycle with read_data valid.
// Reset: registers take their defaults, then busy stays high for a clearing pass that zeroes
//   MAX_PITCH_BYTES*MAX_ROWS entries (2048 by default); config writes are taken throughout.
module mono_framebuffer_engine_top #(
	parameter int MAX_PITCH_BYTES = fbe_pkg::MAX_PITCH_BYTES_DEF,
	parameter int MAX_ROWS        = fbe_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    action,
	input  logic signed [11:0]            pos_x,
	input  logic signed [11:0]            pos_y,
	input  logic signed [11:0]            span,
	input  logic [10:0]                   rows,
	input  logic [7:0]                    pixel_bits,
	input  logic [7:0]                    write_mask,
	input  logic                          color,
	// result channel
	output logic                          done,
	output logic [7:0]                    read_data,
	// configuration write port
	input  logic                          cfg_write,
	input  logic [fbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbe_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_PITCH_BYTES * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fbe_pkg::geom_t geom;

	// frame store port signals
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// width, height and pitch are saturated here so the sequencer sees safe geometry
	fbe_regs #(
		.MAX_PITCH_BYTES(MAX_PITCH_BYTES),
		.MAX_ROWS       (MAX_ROWS)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.geom     (geom)
	);

	// clipping, byte walk and read-modify-write; also runs the clearing pass
	fbe_seq #(
		.MAX_PITCH_BYTES(MAX_PITCH_BYTES),
		.MAX_ROWS       (MAX_ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.span      (span),
		.rows      (rows),
		.pixel_bits(pixel_bits),
		.write_mask(write_mask),
		.color     (color),
		.geom      (geom),
		.done      (done),
		.read_data (read_data),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// one byte per entry, row-major with the programmed pitch, MSB is leftmost pixel
	fbe_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

endmodule

>>> hw/rtl/fbe_ram.sv
// Generic simple dual-port RAM with registered read.
module fbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/fbe_regs.sv
// Configuration registers and effective geometry.
module fbe_regs #(
	parameter int MAX_PITCH_BYTES = fbe_pkg::MAX_PITCH_BYTES_DEF,
	parameter int MAX_ROWS        = fbe_pkg::MAX_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbe_pkg::CFG_DATA_W-1:0] cfg_data,
	output fbe_pkg::geom_t                geom
);

	logic [8:0] width_q;
	logic [6:0] height_q;
	logic [5:0] pitch_q;
	logic       bg_q;
	logic [5:0] pitch_eff;
	logic [6:0] height_eff;
	logic [8:0] pitch_px;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fbe_pkg::WIDTH_RST;
			height_q <= fbe_pkg::HEIGHT_RST;
			pitch_q  <= fbe_pkg::PITCH_RST;
			bg_q     <= 1'b0;
		end else if (cfg_write) begin
			case (fbe_pkg::reg_idx_t'(cfg_index))
				fbe_pkg::REG_WIDTH:  width_q  <= cfg_data[8:0];
				fbe_pkg::REG_HEIGHT: height_q <= cfg_data[6:0];
				fbe_pkg::REG_PITCH:  pitch_q  <= cfg_data[5:0];
				fbe_pkg::REG_BG:     bg_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pitch_q == 6'd0) begin
			pitch_eff = fbe_pkg::PITCH_MIN;
		end else if (32'(pitch_q) > MAX_PITCH_BYTES) begin
			pitch_eff = 6'(MAX_PITCH_BYTES);
		end else begin
			pitch_eff = pitch_q;
		end
		if (32'(height_q) > MAX_ROWS) begin
			height_eff = 7'(MAX_ROWS);
		end else begin
			height_eff = height_q;
		end
		pitch_px = {pitch_eff, 3'b000};
		geom.width  = (width_q > pitch_px) ? pitch_px : width_q;
		geom.height = height_eff;
		geom.pitch  = pitch_eff;
		geom.bg     = bg_q;
	end

endmodule

>>> hw/rtl/fbe_seq.sv
// Request sequencer: clipping, byte walk and read-modify-write of the frame store.
module fbe_seq #(
	parameter int MAX_PITCH_BYTES = fbe_pkg::MAX_PITCH_BYTES_DEF,
	parameter int MAX_ROWS        = fbe_pkg::MAX_ROWS_DEF,
	localparam int DEPTH = MAX_PITCH_BYTES * MAX_ROWS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic signed [11:0] span,
	input  logic [10:0]        rows,
	input  logic [7:0]         pixel_bits,
	input  logic [7:0]         write_mask,
	input  logic               color,
	input  fbe_pkg::geom_t     geom,
	output logic               done,
	output logic [7:0]         read_data,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic [7:0]         ram_wdata,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	input  logic [7:0]         ram_rdata
);

	fbe_pkg::state_t  state_q, state_d;
	fbe_pkg::action_t act_q, act_in;

	logic [2:0]        off_q;
	logic signed [9:0] bc_q, bc_first_q, bc_last_q;
	logic [6:0]        ry_q, ylast_q;
	logic [8:0]        x0_q, x1_q;
	logic [15:0]       wd_q, wm_q, acc_q;
	logic              rowok_q, vis0_q, color_q;
	logic [AW-1:0]     clr_q;
	logic              done_q;
	logic [7:0]        rdata_q;

	// request decode
	logic              accept, op_known, go_mem;
	logic signed [12:0] xs, ys, sp, ye, wsg, hsg;
	logic signed [12:0] xa, xb, xlo, xhi, ylo, yhi;
	logic               fill_empty, rowok_in, vis0_in;
	logic signed [9:0]  bx;
	logic [7:0]         dsel, msel;

	// per-byte work
	logic [12:0]  prod;
	logic [13:0]  sum;
	logic [AW-1:0] byte_addr;
	logic [7:0]   vis, fsel, wdb, wmb, m, d, vis_data;
	logic         first, is_fill, is_wr, last_byte;
	logic [15:0]  acc_d, sh;
	logic [7:0]   result;

	assign accept = start && !busy;
	assign act_in = fbe_pkg::action_t'(action);

	always_comb begin
		xs  = 13'(pos_x);
		ys  = 13'(pos_y);
		sp  = 13'(span);
		ye  = ys + $signed({2'b00, rows});
		wsg = $signed({4'b0000, geom.width});
		hsg = $signed({6'b000000, geom.height});
		if (sp < 0) begin
			xa = xs + sp;
			xb = xs;
		end else begin
			xa = xs;
			xb = xs + sp;
		end
		xlo = (xa < 0) ? 13'sd0 : xa;
		xhi = (xb > wsg) ? wsg : xb;
		ylo = (ys < 0) ? 13'sd0 : ys;
		yhi = (ye > hsg) ? hsg : ye;
		fill_empty = (xlo >= xhi) || (ylo >= yhi);
		rowok_in = (ys >= 0) && (ys < hsg);
		vis0_in  = rowok_in && (xs >= 0) && (xs < wsg);
		bx = 10'(pos_x >>> 3);
		if (act_in == fbe_pkg::ACT_SET) begin
			dsel = color ? fbe_pkg::PIX_MSB : 8'h00;
			msel = fbe_pkg::PIX_MSB;
		end else begin
			dsel = pixel_bits;
			msel = write_mask;
		end
		case (act_in)
			fbe_pkg::ACT_SET, fbe_pkg::ACT_GET, fbe_pkg::ACT_WR8,
			fbe_pkg::ACT_RD8: op_known = 1'b1;
			fbe_pkg::ACT_FILL: op_known = !fill_empty;
			default: op_known = 1'b0;
		endcase
		go_mem = accept && op_known;
	end

	// byte address and modify
	always_comb begin
		prod = ry_q * geom.pitch;
		sum  = {1'b0, prod} + {8'h00, bc_q[5:0]};
		byte_addr = AW'(sum);
		for (int j = 0; j < 8; j++) begin
			logic signed [12:0] c;
			c = {bc_q, 3'(j)};
			vis[7-j]  = (c >= 0) && (c < wsg);
			fsel[7-j] = (c >= $signed({4'b0000, x0_q})) && (c < $signed({4'b0000, x1_q}));
		end
		first   = (bc_q == bc_first_q);
		wdb     = first ? wd_q[15:8] : wd_q[7:0];
		wmb     = first ? wm_q[15:8] : wm_q[7:0];
		is_fill = (act_q == fbe_pkg::ACT_FILL);
		is_wr   = is_fill || (act_q == fbe_pkg::ACT_SET) || (act_q == fbe_pkg::ACT_WR8);
		m = is_fill ? fsel : (wmb & vis & {8{rowok_q}});
		d = is_fill ? {8{color_q}} : wdb;
		vis_data = ram_rdata & vis;
		acc_d = first ? {vis_data, acc_q[7:0]} : {acc_q[15:8], vis_data};
		sh    = acc_d << off_q;
		last_byte = (bc_q == bc_last_q) && (ry_q == ylast_q);
		case (act_q)
			fbe_pkg::ACT_GET: result = {7'b0, vis0_q ? sh[15] : geom.bg};
			fbe_pkg::ACT_RD8: result = rowok_q ? sh[15:8] : (geom.bg ? fbe_pkg::BYTE_ONES : 8'h00);
			default:          result = 8'h00;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbe_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = byte_addr;
		ram_wdata = (ram_rdata & ~m) | (d & m);
		ram_re    = 1'b0;
		ram_raddr = byte_addr;
		case (state_q)
			fbe_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'h00;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = fbe_pkg::ST_IDLE;
				end
			end
			fbe_pkg::ST_IDLE: begin
				if (go_mem) begin
					state_d = fbe_pkg::ST_READ;
				end
			end
			fbe_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = fbe_pkg::ST_WRITE;
			end
			fbe_pkg::ST_WRITE: begin
				ram_we  = is_wr && (m != 8'h00);
				state_d = last_byte ? fbe_pkg::ST_IDLE : fbe_pkg::ST_READ;
			end
			default: state_d = fbe_pkg::ST_IDLE;
		endcase
	end

	assign busy      = (state_q != fbe_pkg::ST_IDLE);
	assign done      = done_q;
	assign read_data = rdata_q;

	// control counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (state_q == fbe_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= (accept && !op_known) || (state_q == fbe_pkg::ST_WRITE && last_byte);
		end
	end

	// request payload and byte walk
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= 8'h00;
		end else if (state_q == fbe_pkg::ST_WRITE && last_byte) begin
			rdata_q <= result;
		end
		if (go_mem) begin
			act_q   <= act_in;
			off_q   <= pos_x[2:0];
			rowok_q <= rowok_in;
			vis0_q  <= vis0_in;
			color_q <= color;
			wd_q    <= {dsel, 8'h00} >> pos_x[2:0];
			wm_q    <= {msel, 8'h00} >> pos_x[2:0];
			acc_q   <= '0;
			x0_q    <= xlo[8:0];
			x1_q    <= xhi[8:0];
			if (act_in == fbe_pkg::ACT_FILL) begin
				bc_q       <= 10'(xlo >>> 3);
				bc_first_q <= 10'(xlo >>> 3);
				bc_last_q  <= 10'((xhi - 13'sd1) >>> 3);
				ry_q       <= ylo[6:0];
				ylast_q    <= 7'(yhi - 13'sd1);
			end else begin
				bc_q       <= bx;
				bc_first_q <= bx;
				bc_last_q  <= (act_in == fbe_pkg::ACT_WR8 || act_in == fbe_pkg::ACT_RD8)
				              ? bx + 10'sd1 : bx;
				ry_q       <= pos_y[6:0];
				ylast_q    <= pos_y[6:0];
			end
		end else if (state_q == fbe_pkg::ST_WRITE) begin
			acc_q <= acc_d;
			if (bc_q == bc_last_q) begin
				bc_q <= bc_first_q;
				ry_q <= ry_q + 7'd1;
			end else begin
				bc_q <= bc_q + 10'sd1;
			end
		end
	end

	// read-only requests never touch the store
	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbe_pkg::ST_WRITE &&
		 (act_q == fbe_pkg::ACT_GET || act_q == fbe_pkg::ACT_RD8)) |-> !ram_we)
		else $error("write during read request");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == fbe_pkg::ST_WRITE) |-> (32'(ram_waddr) < DEPTH))
		else $error("store write beyond depth");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q == fbe_pkg::ST_WRITE) ||
		            $past(start && state_q == fbe_pkg::ST_IDLE)))
		else $error("result strobe without a finished request");

	a_read_then_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbe_pkg::ST_READ) |=> (state_q == fbe_pkg::ST_WRITE))
		else $error("read not followed by modify cycle");

endmodule

>>> test/fbe_pixel_checker.sv
// Checker for the mono frame buffer engine: shadow frame store, reply prediction, compare.
module fbe_pixel_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [2:0]                     action,
	input  logic signed [11:0]             pos_x,
	input  logic signed [11:0]             pos_y,
	input  logic signed [11:0]             span,
	input  logic [10:0]                    rows,
	input  logic [7:0]                     pixel_bits,
	input  logic [7:0]                     write_mask,
	input  logic                           color,
	input  logic                           done,
	input  logic [7:0]                     read_data,
	input  logic                           cfg_write,
	input  logic [fbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbe_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             outstanding,
	output int                             mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import fbe_pkg::*;

	localparam int STORE_BYTES = MAX_PITCH_BYTES_DEF * MAX_ROWS_DEF;

	typedef struct {
		logic [2:0] op;
		int         x;
		int         y;
		logic [7:0] data;
	} pixel_reply_t;

	logic [7:0]   shadow_store [0:STORE_BYTES-1];
	logic [8:0]   width_reg;
	logic [6:0]   height_reg;
	logic [5:0]   pitch_reg;
	logic         bg_reg;
	pixel_reply_t expected_replies [$];
	int           errors;

	function automatic int pitch_used();
		int p;
		p = pitch_reg;
		if (p < 1) p = 1;
		if (p > MAX_PITCH_BYTES_DEF) p = MAX_PITCH_BYTES_DEF;
		return p;
	endfunction

	function automatic int height_used();
		return (height_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(height_reg);
	endfunction

	function automatic int width_used();
		int lim;
		lim = 8 * pitch_used();
		return (width_reg > lim) ? lim : int'(width_reg);
	endfunction

	function automatic bit on_screen(int x, int y);
		return x >= 0 && x < width_used() && y >= 0 && y < height_used();
	endfunction

	function automatic int byte_addr(int x, int y);
		return (y * pitch_used() + x / 8) % STORE_BYTES;
	endfunction

	function automatic void plot(int x, int y, logic c);
		int         a;
		logic [7:0] bit_sel;
		if (!on_screen(x, y)) return;
		a = byte_addr(x, y);
		bit_sel = PIX_MSB >> (x % 8);
		if (c) shadow_store[a] = shadow_store[a] | bit_sel;
		else   shadow_store[a] = shadow_store[a] & ~bit_sel;
	endfunction

	function automatic logic pixel_at(int x, int y);
		return shadow_store[byte_addr(x, y)][7 - (x % 8)];
	endfunction

	// applies one request to the shadow store and returns the reply byte
	function automatic logic [7:0] predict_reply(logic [2:0] op, int x, int y, int sp, int nr,
			logic [7:0] bits, logic [7:0] mask, logic c);
		logic [7:0] reply;
		int         x0, x1, y0, y1;
		reply = '0;
		case (op)
			ACT_SET: plot(x, y, c);
			ACT_GET: reply[0] = on_screen(x, y) ? pixel_at(x, y) : bg_reg;
			ACT_WR8: begin
				for (int i = 0; i < 8; i++)
					if (mask[7-i]) plot(x + i, y, bits[7-i]);
			end
			ACT_RD8: begin
				if (y < 0 || y >= height_used())
					reply = bg_reg ? BYTE_ONES : '0;
				else
					for (int i = 0; i < 8; i++)
						if (on_screen(x + i, y)) reply[7-i] = pixel_at(x + i, y);
			end
			ACT_FILL: begin
				x0 = (sp < 0) ? x + sp : x;
				x1 = (sp < 0) ? x : x + sp;
				y0 = y;
				y1 = y + nr;
				if (x0 < 0) x0 = 0;
				if (x1 > width_used()) x1 = width_used();
				if (y0 < 0) y0 = 0;
				if (y1 > height_used()) y1 = height_used();
				for (int r = y0; r < y1; r++)
					for (int cc = x0; cc < x1; cc++)
						plot(cc, r, c);
			end
			default: ;
		endcase
		return reply;
	endfunction

	function automatic void count_mismatch(string msg);
		errors++;
		if (errors <= 10) $display("%t: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_reply_t got;
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = '0;
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			pitch_reg  = PITCH_RST;
			bg_reg     = 1'b0;
			expected_replies.delete();
			errors = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WIDTH:  width_reg  = cfg_data[8:0];
					REG_HEIGHT: height_reg = cfg_data[6:0];
					REG_PITCH:  pitch_reg  = cfg_data[5:0];
					REG_BG:     bg_reg     = cfg_data[0];
					default: ;
				endcase
			end
			// result of the previous request retires before a new one transfers
			if (done) begin
				if (expected_replies.size() == 0) begin
					count_mismatch($sformatf("unexpected reply read_data=%02h", read_data));
				end else begin
					got = expected_replies.pop_front();
					if (read_data !== got.data)
						count_mismatch($sformatf(
							"action %0d at (%0d,%0d): read_data expected %02h got %02h",
							got.op, got.x, got.y, got.data, read_data));
				end
			end
			if (start && !busy) begin
				got.op   = action;
				got.x    = pos_x;
				got.y    = pos_y;
				got.data = predict_reply(action, pos_x, pos_y, span, rows,
					pixel_bits, write_mask, color);
				expected_replies.push_back(got);
			end
			outstanding <= expected_replies.size();
			mismatches  <= errors;
		end
	end

endmodule

>>> test/mono_framebuffer_engine_top_tb.sv
// Testbench top for the mono frame buffer engine: stimulus, watchdog and verdict.
module mono_framebuffer_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbe_pkg::*;

	// worst case with no transfer: clearing pass (2048 entries) or a full-screen fill
	// (32 bytes x 64 rows), plus sender gaps; several times over
	localparam int         WATCHDOG_CYCLES = 20000;
	localparam int         RANDOM_PHASES   = 12;
	localparam int         ITEMS_PER_PHASE = 96;
	// first code past the defined actions; 5..7 must be ignored by the block
	localparam logic [2:0] ACT_RESERVED    = 3'd5;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  busy;
	logic [2:0]            action     = '0;
	logic signed [11:0]    pos_x      = '0;
	logic signed [11:0]    pos_y      = '0;
	logic signed [11:0]    span       = '0;
	logic [10:0]           rows       = '0;
	logic [7:0]            pixel_bits = '0;
	logic [7:0]            write_mask = '0;
	logic                  color      = 1'b0;
	logic                  done;
	logic [7:0]            read_data;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	int outstanding;
	int mismatches;

	// stimulus bookkeeping
	bit idle_on = 1'b1;
	int cur_width  = WIDTH_RST;
	int cur_height = HEIGHT_RST;
	int n_action [8];
	int n_reg_writes;
	int n_phases;
	int stall_cycles;

	mono_framebuffer_engine_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.span       (span),
		.rows       (rows),
		.pixel_bits (pixel_bits),
		.write_mask (write_mask),
		.color      (color),
		.done       (done),
		.read_data  (read_data),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// watches both channels and the config port, predicts every reply
	fbe_pixel_checker u_pixel_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.span        (span),
		.rows        (rows),
		.pixel_bits  (pixel_bits),
		.write_mask  (write_mask),
		.color       (color),
		.done        (done),
		.read_data   (read_data),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("watchdog: no transfer for %0d cycles, %0d replies still due",
				stall_cycles, outstanding);
			$display("mono_framebuffer_engine_top_tb: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One request. Random gaps with start low go in front of it; start stays high
	// from one transfer into the next when no gap is drawn.
	task automatic issue_request(input logic [2:0] op, input int x, input int y,
			input int sp, input int nr, input logic [7:0] bits, input logic [7:0] mask,
			input logic c);
		if (idle_on)
			while ($urandom_range(0, 99) < 35) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start      <= 1'b1;
		action     <= op;
		pos_x      <= 12'(x);
		pos_y      <= 12'(y);
		span       <= 12'(sp);
		rows       <= 11'(nr);
		pixel_bits <= bits;
		write_mask <= mask;
		color      <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_action[op]++;
	endtask

	// stop sending and wait for every predicted reply, then for the block to go idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		n_reg_writes++;
	endtask

	// new geometry only with the engine idle and nothing in flight
	task automatic set_geometry(input int w, input int h, input int p, input int bg);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_PITCH, p);
		write_reg(REG_BG, bg);
		cur_width  = w;
		cur_height = h;
		n_phases++;
	endtask

	// Mostly coordinates around the visible window so that writes land and reads
	// see them; one in ten draws every field from its whole range.
	task automatic random_request();
		int         sel, xr, yr, x, y, sp, nr;
		logic [2:0] op;
		xr  = (cur_width > 256) ? 256 : cur_width;
		yr  = (cur_height > 64) ? 64 : cur_height;
		sel = $urandom_range(0, 99);
		if (sel < 15)      op = ACT_SET;
		else if (sel < 35) op = ACT_GET;
		else if (sel < 55) op = ACT_WR8;
		else if (sel < 80) op = ACT_RD8;
		else if (sel < 95) op = ACT_FILL;
		else               op = 3'(ACT_RESERVED + $urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0) begin
			x  = $signed(12'($urandom));
			y  = $signed(12'($urandom));
			sp = $signed(12'($urandom));
			nr = $urandom_range(0, 2047);
		end else begin
			x  = $urandom_range(0, xr + 23) - 12;
			y  = $urandom_range(0, yr + 5) - 3;
			sp = $urandom_range(0, 80) - 40;
			nr = $urandom_range(0, 10);
		end
		issue_request(op, x, y, sp, nr, 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int w, h, p, bg;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// engine clears its store after reset; busy covers that pass
		drain();

		// directed: reset geometry 128 x 64, pitch 16, black background
		issue_request(ACT_SET, 0, 0, 0, 0, '0, '0, 1'b1);
		issue_request(ACT_GET, 0, 0, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_SET, 127, 63, 0, 0, '0, '0, 1'b1);
		issue_request(ACT_GET, 127, 63, 0, 0, '0, '0, 1'b0);
		// off-screen single pixels read as the background
		issue_request(ACT_GET, -1, 0, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_GET, 128, 0, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_GET, 0, 64, 0, 0, '0, '0, 1'b0);
		// eight-pixel write starting left of column zero
		issue_request(ACT_WR8, -3, 1, 0, 0, 8'hA5, 8'hFF, 1'b0);
		issue_request(ACT_RD8, -3, 1, 0, 0, '0, '0, 1'b0);
		// masked write across the right edge (width is a multiple of 8)
		issue_request(ACT_WR8, 124, 2, 0, 0, 8'hFF, 8'h0F, 1'b0);
		issue_request(ACT_RD8, 120, 2, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_RD8, 124, 2, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_WR8, 40, 2, 0, 0, 8'h00, 8'h00, 1'b1);
		// eight-pixel reads on rows above and below the image
		issue_request(ACT_RD8, 0, -1, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_RD8, 0, 64, 0, 0, '0, '0, 1'b0);
		// short span inside one byte
		issue_request(ACT_FILL, 10, 3, 3, 2, '0, '0, 1'b1);
		issue_request(ACT_RD8, 8, 3, 0, 0, '0, '0, 1'b0);
		// negative span that runs past the left edge
		issue_request(ACT_FILL, 20, 5, -30, 3, '0, '0, 1'b1);
		issue_request(ACT_RD8, 0, 5, 0, 0, '0, '0, 1'b0);
		// zero span and zero rows leave the store alone
		issue_request(ACT_FILL, 30, 6, 0, 5, '0, '0, 1'b1);
		issue_request(ACT_FILL, 30, 6, 5, 0, '0, '0, 1'b1);
		// field extremes: whole-screen white, then cleared back with a negative span
		issue_request(ACT_FILL, -100, -5, 2047, 2047, 8'hFF, 8'hFF, 1'b1);
		issue_request(ACT_RD8, 64, 32, 0, 0, '0, '0, 1'b0);
		issue_request(ACT_FILL, 2047, 0, -2048, 64, 8'hFF, 8'hFF, 1'b0);
		for (int a = ACT_RESERVED; a < 8; a++)
			issue_request(3'(a), 2047, 2047, 2047, 2047, 8'hFF, 8'hFF, 1'b1);

		// random part: fixed corner geometries first, then random ones; every
		// phase starts from a drained engine so the sender pause happens each time
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin w = 256; h = 64;  p = 32; bg = 1; end
				1: begin w = 1;   h = 1;   p = 1;  bg = 0; end
				2: begin w = 64;  h = 17;  p = 8;  bg = 1; end
				3: begin w = 100; h = 40;  p = 13; bg = 0; end
				4: begin w = 511; h = 127; p = 63; bg = 1; end
				5: begin w = 8;   h = 127; p = 0;  bg = 1; end  // pitch saturates up to 1
				6: begin w = 200; h = 64;  p = 5;  bg = 0; end  // width limited by pitch
				7: begin w = 0;   h = 0;   p = 17; bg = 1; end  // nothing visible
				default: begin
					w  = $urandom_range(0, 511);
					h  = $urandom_range(0, 127);
					p  = $urandom_range(0, 63);
					bg = $urandom_range(0, 1);
				end
			endcase
			set_geometry(w, h, p, bg);
			// phase 3 runs back to back with no sender gaps
			idle_on = (ph != 3);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_request();
		end

		drain();
		repeat (8) @(posedge clk);

		$display("requests: %0d set, %0d get, %0d write-8, %0d read-8, %0d fill, %0d reserved",
			n_action[ACT_SET], n_action[ACT_GET], n_action[ACT_WR8], n_action[ACT_RD8],
			n_action[ACT_FILL], n_action[5] + n_action[6] + n_action[7]);
		$display("geometry: %0d settings via %0d register writes, incl. saturated and empty ones",
			n_phases, n_reg_writes);
		if (mismatches == 0) begin
			$display("mono_framebuffer_engine_top_tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("mono_framebuffer_engine_top_tb: FAIL");
		end
		$finish;
	end

endmodule
